@@ rtl/core/tsvf_pkg.sv @@
package tsvf_pkg;

   // Field and register widths
   localparam int SAMPLE_W    = 24;
   localparam int STATE_W     = 32;
   localparam int COEF_W      = 17;
   localparam int DAMP_W      = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   // Datapath widths: operand holds v1 (36 bits) and v3 (33 bits) sign-extended
   localparam int FRAC   = 16;
   localparam int OPND_W = 37;
   localparam int PROD_W = 56;
   localparam int RND_W  = PROD_W - FRAC;
   localparam int V3_W   = 33;
   localparam int V1_W   = 36;
   localparam int V2_W   = 37;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   localparam logic signed [RND_W-1:0] STATE_MAX  = RND_W'(64'sd2147483647);
   localparam logic signed [RND_W-1:0] STATE_MIN  = RND_W'(-64'sd2147483648);
   localparam logic signed [RND_W-1:0] SAMPLE_MAX = RND_W'(64'sd8388607);
   localparam logic signed [RND_W-1:0] SAMPLE_MIN = RND_W'(-64'sd8388608);

   // Register reset values
   localparam logic [COEF_W-1:0] A1_RESET = COEF_W'(65536);
   localparam logic [DAMP_W-1:0] K_RESET  = DAMP_W'(131072);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_A1     = 3'd0,
      CSR_COEF_A2     = 3'd1,
      CSR_COEF_A3     = 3'd2,
      CSR_DAMPING_K   = 3'd3,
      CSR_FILTER_TYPE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FILTER_LOW  = 2'd0,
      FILTER_BAND = 2'd1,
      FILTER_HIGH = 2'd2
   } filter_type_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_MUL_E,
      ST_FIN_V2,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      MUL_A1_S1,
      MUL_A2_V3,
      MUL_A2_S1,
      MUL_A3_V3,
      MUL_K_V1
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_x;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        v1_load;
      logic        v2_load;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
      logic [COEF_W-1:0] a3;
      logic [DAMP_W-1:0] k;
      logic [1:0]        filter_type;
   } coef_type;

   // Clamp to the signed 32-bit integrator range
   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] c;
      begin
         if (v > STATE_MAX) begin
            c = STATE_MAX;
         end else if (v < STATE_MIN) begin
            c = STATE_MIN;
         end else begin
            c = v;
         end
         return c[STATE_W-1:0];
      end
   endfunction

   // Clamp to the Q1.23 sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] c;
      begin
         if (v > SAMPLE_MAX) begin
            c = SAMPLE_MAX;
         end else if (v < SAMPLE_MIN) begin
            c = SAMPLE_MIN;
         end else begin
            c = v;
         end
         return c[SAMPLE_W-1:0];
      end
   endfunction

endpackage

@@ rtl/core/tsvf_csr.sv @@
module tsvf_csr
   import tsvf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output coef_type               coef
);

   coef_type coef_ff;
   coef_type coef_in;

   // Decode the write; drop indexes past the register list
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_A1:     coef_in.a1          = csr_data[COEF_W-1:0];
            CSR_COEF_A2:     coef_in.a2          = csr_data[COEF_W-1:0];
            CSR_COEF_A3:     coef_in.a3          = csr_data[COEF_W-1:0];
            CSR_DAMPING_K:   coef_in.k           = csr_data[DAMP_W-1:0];
            CSR_FILTER_TYPE: coef_in.filter_type = csr_data[1:0];
            default:         coef_in             = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.a1          <= A1_RESET;
         coef_ff.a2          <= '0;
         coef_ff.a3          <= '0;
         coef_ff.k           <= K_RESET;
         coef_ff.filter_type <= FILTER_LOW;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

@@ rtl/core/tsvf_ctrl.sv @@
module tsvf_ctrl
   import tsvf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence the five products through the shared multiplier
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_A1_S1;
      cmd.acc_op   = ACC_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_sel = MUL_A1_S1;
            state_in    = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_sel = MUL_A2_V3;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul_sel = MUL_A2_S1;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_sel = MUL_A3_V3;
            cmd.acc_op  = ACC_LOAD;
            cmd.v1_load = 1'b1;
            state_in    = ST_MUL_E;
         end
         ST_MUL_E: begin
            cmd.mul_sel = MUL_K_V1;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_FIN_V2;
         end
         ST_FIN_V2: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.v2_load = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            // Hold until the output word register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Raise valid on commit, drop it once the word is taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/tsvf_dp.sv @@
module tsvf_dp
   import tsvf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  coef_type                   coef,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic signed [SAMPLE_W-1:0] rsp_selected_out,
   output logic signed [SAMPLE_W-1:0] rsp_lowpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_bandpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_highpass_out
);

   logic signed [STATE_W-1:0]  s1_ff, s1_in;
   logic signed [STATE_W-1:0]  s2_ff, s2_in;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [V3_W-1:0]     v3_ff, v3_in;
   logic signed [V1_W-1:0]     v1_ff, v1_in;
   logic signed [V2_W-1:0]     v2_ff, v2_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic [DAMP_W-1:0]          mul_coef;
   logic signed [OPND_W-1:0]   mul_opnd;
   logic signed [RND_W-1:0]    rnd;
   logic signed [RND_W-1:0]    hp_full;
   logic signed [RND_W-1:0]    s1_full;
   logic signed [RND_W-1:0]    s2_full;
   logic signed [SAMPLE_W-1:0] lp_sat, bp_sat, hp_sat, sel_sat;
   logic signed [SAMPLE_W-1:0] sel_out_ff, lp_out_ff, bp_out_ff, hp_out_ff;

   // Input difference v3 = x - s2
   assign v3_in = V3_W'(req_sample_in) - V3_W'(s2_ff);

   // Pick the multiplier operands
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_A1_S1: begin
            mul_coef = DAMP_W'(coef.a1);
            mul_opnd = OPND_W'(s1_ff);
         end
         MUL_A2_V3: begin
            mul_coef = DAMP_W'(coef.a2);
            mul_opnd = OPND_W'(v3_ff);
         end
         MUL_A2_S1: begin
            mul_coef = DAMP_W'(coef.a2);
            mul_opnd = OPND_W'(s1_ff);
         end
         MUL_A3_V3: begin
            mul_coef = DAMP_W'(coef.a3);
            mul_opnd = OPND_W'(v3_ff);
         end
         MUL_K_V1: begin
            mul_coef = coef.k;
            mul_opnd = OPND_W'(v1_ff);
         end
         default: begin
            mul_coef = '0;
            mul_opnd = '0;
         end
      endcase
   end

   assign prod_in = $signed({1'b0, mul_coef}) * mul_opnd;

   // Accumulate registered products; a load adds the rounding half
   always_comb begin
      unique case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ff + ROUND_HALF;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // Rounded product sum: floor shift by the coefficient fraction
   assign rnd   = acc_ff[PROD_W-1:FRAC];
   assign v1_in = rnd[V1_W-1:0];
   assign v2_in = V2_W'(RND_W'(s2_ff) + rnd);

   // Highpass and integrator updates
   assign hp_full = RND_W'(x_ff) - rnd - RND_W'(v2_ff);
   assign s1_full = RND_W'($signed({v1_ff, 1'b0})) - RND_W'(s1_ff);
   assign s2_full = RND_W'($signed({v2_ff, 1'b0})) - RND_W'(s2_ff);
   assign s1_in   = sat_state(s1_full);
   assign s2_in   = sat_state(s2_full);

   assign lp_sat = sat_sample(RND_W'(v2_ff));
   assign bp_sat = sat_sample(RND_W'(v1_ff));
   assign hp_sat = sat_sample(hp_full);

   // Unused type code falls back to lowpass
   always_comb begin
      unique case (coef.filter_type)
         FILTER_BAND: sel_sat = bp_sat;
         FILTER_HIGH: sel_sat = hp_sat;
         default:     sel_sat = lp_sat;
      endcase
   end

   // Integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (cmd.commit) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.load_x) begin
         x_ff  <= req_sample_in;
         v3_ff <= v3_in;
      end
      if (cmd.v1_load) begin
         v1_ff <= v1_in;
      end
      if (cmd.v2_load) begin
         v2_ff <= v2_in;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         sel_out_ff <= sel_sat;
         lp_out_ff  <= lp_sat;
         bp_out_ff  <= bp_sat;
         hp_out_ff  <= hp_sat;
      end
   end

   assign rsp_selected_out = sel_out_ff;
   assign rsp_lowpass_out  = lp_out_ff;
   assign rsp_bandpass_out = bp_out_ff;
   assign rsp_highpass_out = hp_out_ff;

endmodule

@@ rtl/core/tpt_state_variable_filter.sv @@
// Channel   Handshake            Payload
// req       req_valid/req_stall  req_sample_in (s24)
// rsp       rsp_valid/rsp_stall  rsp_selected_out, rsp_lowpass_out,
//                                rsp_bandpass_out, rsp_highpass_out (s24)
// csr       csr_valid/csr_ready  csr_index (3), csr_data (18)
//
// Each sample passes through an accept state, five products through the one
// shared 19x37 multiplier, a state to form v2 and a commit state.
// The word is valid the cycle after commit; a new sample may enter meanwhile.
// A stalled output word holds the commit stage until it is taken.
// Reset is synchronous: integrators clear, registers take their reset values.
// csr_ready is always high.
module tpt_state_variable_filter
   import tsvf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_selected_out,
   output logic signed [SAMPLE_W-1:0] rsp_lowpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_bandpass_out,
   output logic signed [SAMPLE_W-1:0] rsp_highpass_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cmd_type  cmd;
   coef_type coef;

   assign csr_ready = 1'b1;

   tsvf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   tsvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tsvf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .coef             (coef),
      .req_sample_in    (req_sample_in),
      .rsp_selected_out (rsp_selected_out),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_highpass_out (rsp_highpass_out)
   );

endmodule

@@ rtl/core/tsvf_check.sv @@
module tsvf_check
   import tsvf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_selected_out,
   input logic signed [SAMPLE_W-1:0] rsp_lowpass_out,
   input logic signed [SAMPLE_W-1:0] rsp_bandpass_out,
   input logic signed [SAMPLE_W-1:0] rsp_highpass_out
);

   // Reset leaves no word pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // An accepted sample blocks the input for its tick
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second sample accepted during a tick");

   // Selected word is always one of the three filter outputs
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_selected_out == rsp_lowpass_out) ||
                    (rsp_selected_out == rsp_bandpass_out) ||
                    (rsp_selected_out == rsp_highpass_out))
      else $error("selected output matches no filter output");

   // A stalled word stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled word dropped");

   // A stalled word holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_lowpass_out) && $stable(rsp_bandpass_out) &&
                                 $stable(rsp_highpass_out))
      else $error("stalled payload changed");

endmodule

bind tpt_state_variable_filter tsvf_check u_tsvf_check (.*);

@@ sim/filter_tick_checker.sv @@
`timescale 1ns / 1ps

module filter_tick_checker
   import tsvf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_selected_out,
   input  logic signed [SAMPLE_W-1:0] rsp_lowpass_out,
   input  logic signed [SAMPLE_W-1:0] rsp_bandpass_out,
   input  logic signed [SAMPLE_W-1:0] rsp_highpass_out,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         bad_words,
   output int                         words_pending
);

   localparam longint STATE_CEIL  = 64'sd2147483647;
   localparam longint STATE_FLOOR = -64'sd2147483648;
   localparam longint AUDIO_CEIL  = 64'sd8388607;
   localparam longint AUDIO_FLOOR = -64'sd8388608;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] selected;
      logic signed [SAMPLE_W-1:0] lowpass;
      logic signed [SAMPLE_W-1:0] bandpass;
      logic signed [SAMPLE_W-1:0] highpass;
   } filter_word_type;

   // Shadow copy of the filter registers and integrators
   logic [COEF_W-1:0]         tap_a1;
   logic [COEF_W-1:0]         tap_a2;
   logic [COEF_W-1:0]         tap_a3;
   logic [DAMP_W-1:0]         tap_k;
   logic [1:0]                out_mode;
   logic signed [STATE_W-1:0] integ_one;
   logic signed [STATE_W-1:0] integ_two;

   filter_word_type tick_results[$];
   int              fault_count = 0;

   // Scale a Q2.16 product sum back, rounding half up
   function automatic longint round_q16(input longint acc);
      return (acc + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Run one filter tick on the shadow state and build the output word
   function automatic filter_word_type run_filter_tick(input logic signed [SAMPLE_W-1:0] x_in);
      longint          x, s1, s2, v3, v1, v2, hp;
      filter_word_type w;
      x  = x_in;
      s1 = integ_one;
      s2 = integ_two;
      v3 = x - s2;
      v1 = round_q16(longint'(tap_a1) * s1 + longint'(tap_a2) * v3);
      v2 = s2 + round_q16(longint'(tap_a2) * s1 + longint'(tap_a3) * v3);
      integ_one = STATE_W'(clamp_to(2 * v1 - s1, STATE_FLOOR, STATE_CEIL));
      integ_two = STATE_W'(clamp_to(2 * v2 - s2, STATE_FLOOR, STATE_CEIL));
      hp = x - round_q16(longint'(tap_k) * v1) - v2;
      w.lowpass  = SAMPLE_W'(clamp_to(v2, AUDIO_FLOOR, AUDIO_CEIL));
      w.bandpass = SAMPLE_W'(clamp_to(v1, AUDIO_FLOOR, AUDIO_CEIL));
      w.highpass = SAMPLE_W'(clamp_to(hp, AUDIO_FLOOR, AUDIO_CEIL));
      case (out_mode)
         FILTER_BAND: w.selected = w.bandpass;
         FILTER_HIGH: w.selected = w.highpass;
         default:     w.selected = w.lowpass;
      endcase
      return w;
   endfunction

   function automatic void check_field(input string label,
                                       input logic signed [SAMPLE_W-1:0] want,
                                       input logic signed [SAMPLE_W-1:0] got);
      if (got !== want) begin
         if (fault_count < 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
         end
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      filter_word_type want;
      if (reset) begin
         tap_a1    = A1_RESET;
         tap_a2    = '0;
         tap_a3    = '0;
         tap_k     = K_RESET;
         out_mode  = FILTER_LOW;
         integ_one = '0;
         integ_two = '0;
         tick_results.delete();
      end else begin
         // Track register writes; spare indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_A1:     tap_a1   = csr_data[COEF_W-1:0];
               CSR_COEF_A2:     tap_a2   = csr_data[COEF_W-1:0];
               CSR_COEF_A3:     tap_a3   = csr_data[COEF_W-1:0];
               CSR_DAMPING_K:   tap_k    = csr_data[DAMP_W-1:0];
               CSR_FILTER_TYPE: out_mode = csr_data[1:0];
               default: ;
            endcase
         end
         // Compare an output word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (tick_results.size() == 0) begin
               if (fault_count < 10) begin
                  $display("%0t: output word with no sample pending", $time);
               end
               fault_count++;
            end else begin
               want = tick_results.pop_front();
               check_field("selected", want.selected, rsp_selected_out);
               check_field("lowpass", want.lowpass, rsp_lowpass_out);
               check_field("bandpass", want.bandpass, rsp_bandpass_out);
               check_field("highpass", want.highpass, rsp_highpass_out);
            end
         end
         // Predict the word for each sample taken in
         if (req_valid && !req_stall) begin
            tick_results.push_back(run_filter_tick(req_sample_in));
         end
      end
      bad_words     <= fault_count;
      words_pending <= tick_results.size();
   end

endmodule

@@ sim/tpt_state_variable_filter_test.sv @@
`timescale 1ns / 1ps

module tpt_state_variable_filter_test;
   import tsvf_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 24'sh800000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE    = 24'sd1;
   localparam logic [COEF_W-1:0]      COEF_UNITY   = 17'd65536;
   localparam logic [COEF_W-1:0]      COEF_FULL    = 17'h1FFFF;
   localparam logic [DAMP_W-1:0]      DAMP_UNITY   = 18'd65536;
   localparam logic [DAMP_W-1:0]      DAMP_LEAST   = 18'd1310;
   localparam logic [DAMP_W-1:0]      DAMP_FULL    = 18'h3FFFF;
   localparam logic [1:0]             FILTER_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE    = 3'd7;
   localparam int                     HOLD_CYCLES  = 150;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_selected_out;
   logic signed [SAMPLE_W-1:0] rsp_lowpass_out;
   logic signed [SAMPLE_W-1:0] rsp_bandpass_out;
   logic signed [SAMPLE_W-1:0] rsp_highpass_out;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index     = '0;
   logic [CSR_DATA_W-1:0]      csr_data      = '0;
   int                         bad_words;
   int                         words_pending;
   bit                         quiet         = 1'b0;
   bit                         squeeze       = 1'b0;

   always #5 clock = ~clock;

   tpt_state_variable_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_selected_out (rsp_selected_out),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_highpass_out (rsp_highpass_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   filter_tick_checker watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_selected_out (rsp_selected_out),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_highpass_out (rsp_highpass_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .bad_words        (bad_words),
      .words_pending    (words_pending)
   );

   // Give up well past the slowest legal run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic bit take_break();
      return !quiet && ($urandom_range(99) < 29);
   endfunction

   function automatic logic [COEF_W-1:0] corner_coef();
      case ($urandom_range(2))
         0:       return '0;
         1:       return COEF_UNITY;
         default: return COEF_FULL;
      endcase
   endfunction

   // Offer one sample after a random gap and hold it until taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = 0;
      while (take_break()) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted word has come out
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   // Leaves csr_valid high so back-to-back writes need no second assignment
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Program every register, with junk in unused upper bits, plus a spare index
   task automatic load_setting(input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                               input logic [COEF_W-1:0] a3, input logic [DAMP_W-1:0] k,
                               input logic [1:0] mode);
      write_reg(CSR_COEF_A1, {1'($urandom), a1});
      write_reg(CSR_COEF_A2, {1'($urandom), a2});
      write_reg(CSR_COEF_A3, {1'($urandom), a3});
      write_reg(CSR_DAMPING_K, k);
      write_reg(CSR_FILTER_TYPE, {16'($urandom), mode});
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, one long hold-off when asked
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            hold_left = HOLD_CYCLES;
            held      = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= take_break();
         end
      end
   end

   // Sender: directed corners, then random filter settings with random audio
   initial begin
      int                         n;
      real                        g, damp, gain;
      logic [COEF_W-1:0]          c1, c2, c3;
      logic [DAMP_W-1:0]          kk;
      logic [1:0]                 mode;
      logic signed [SAMPLE_W-1:0] smp;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: unity a1, integrators stay at zero
      send_sample(SAMPLE_TOP);
      send_sample(SAMPLE_BOTTOM);
      send_sample('0);
      drain_block();

      // plain lowpass, full-scale steps both ways
      load_setting(17'd49932, 17'd12483, 17'd3121, DAMP_UNITY, FILTER_LOW);
      repeat (3) send_sample(SAMPLE_TOP);
      repeat (3) send_sample(SAMPLE_BOTTOM);
      send_sample(SAMPLE_ONE);
      send_sample(-SAMPLE_ONE);
      drain_block();

      // out-of-range coefficients drive the states into saturation; unused type
      load_setting(COEF_FULL, COEF_FULL, COEF_FULL, DAMP_FULL, FILTER_SPARE);
      repeat (4) send_sample(SAMPLE_TOP);
      repeat (2) send_sample(SAMPLE_BOTTOM);
      drain_block();

      // highest resonance, bandpass
      load_setting(17'd32444, 17'd32444, 17'd32444, DAMP_LEAST, FILTER_BAND);
      repeat (3) send_sample(SAMPLE_TOP);
      send_sample('0);
      drain_block();

      // all coefficients zero, highpass
      load_setting('0, '0, '0, '0, FILTER_HIGH);
      send_sample(SAMPLE_TOP);
      send_sample(SAMPLE_BOTTOM);
      drain_block();

      for (int phase = 0; phase < 10; phase++) begin
         quiet = (phase == 3);
         case ($urandom_range(9))
            0: begin
               c1 = corner_coef();
               c2 = corner_coef();
               c3 = corner_coef();
               case ($urandom_range(3))
                  0:       kk = '0;
                  1:       kk = DAMP_LEAST;
                  2:       kk = 18'd131072;
                  default: kk = DAMP_FULL;
               endcase
            end
            1: begin
               c1 = COEF_W'($urandom);
               c2 = COEF_W'($urandom);
               c3 = COEF_W'($urandom);
               kk = DAMP_W'($urandom);
            end
            default: begin
               // derive a stable filter from a random prewarped gain and damping
               g    = $urandom_range(1, 4000) / 1000.0;
               damp = $urandom_range(1310, 131072) / 65536.0;
               gain = 1.0 / (1.0 + g * (g + damp));
               c1   = COEF_W'($rtoi(gain * 65536.0 + 0.5));
               c2   = COEF_W'($rtoi(g * gain * 65536.0 + 0.5));
               c3   = COEF_W'($rtoi(g * g * gain * 65536.0 + 0.5));
               kk   = DAMP_W'($rtoi(damp * 65536.0 + 0.5));
            end
         endcase
         mode = 2'($urandom_range(3));
         load_setting(c1, c2, c3, kk, mode);
         if (phase == 6) squeeze <= 1'b1;

         n   = quiet ? 100 : 65;
         smp = '0;
         repeat (n) begin
            // hold the previous sample now and then to get step responses
            if ($urandom_range(3) != 0) begin
               case ($urandom_range(7))
                  0:       smp = SAMPLE_TOP;
                  1:       smp = SAMPLE_BOTTOM;
                  2:       smp = SAMPLE_W'($urandom_range(511)) - 24'sd256;
                  default: smp = SAMPLE_W'($urandom);
               endcase
            end
            send_sample(smp);
         end
         drain_block();
      end

      repeat (20) @(posedge clock);
      if (bad_words == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
